>>> sv/prq_pkg.sv
// prq_pkg: sizes, codes and word types shared by the packet ring queue
// no dependencies; imported by prq_front, prq_back and the top level
package prq_pkg;

	// queue geometry
	localparam int SLOT_BYTES = 64;
	localparam int SLOTS      = 8;

	// derived widths
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int OFS_W  = $clog2(SLOT_BYTES + 1);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int OCC_W  = 4;

	// request command decoded by the front end
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} prq_op_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_WR_OK    = 2'd0,
		KIND_WR_FULL  = 2'd1,
		KIND_RD_DATA  = 2'd2,
		KIND_RD_EMPTY = 2'd3
	} prq_kind_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_LEN,
		ST_RD_DATA
	} prq_state_t;

	// input word
	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} prq_req_t;

	// output word
	typedef struct packed {
		prq_kind_t         kind;
		logic [BYTE_W-1:0] out_byte;
		logic [LEN_W-1:0]  packet_length;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
	} prq_rsp_t;

	// decoded command held in the queue between front and back
	typedef struct packed {
		prq_op_t           op;
		logic [BYTE_W-1:0] data;
		logic              last;
	} prq_cmd_t;

endpackage

>>> sv/prq_ram.sv
// prq_ram: generic simple dual-port ram, one write port, one registered read port
// standalone; used for packet bytes and stored lengths
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write first-come, read returns the old value on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/prq_front.sv
// prq_front: accepts request words, decodes the command and buffers it
// depends on prq_pkg; feeds prq_back through a two-entry queue
module prq_front
	import prq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  prq_req_t req,
	output logic     cmd_valid,
	output prq_cmd_t cmd,
	input  logic     cmd_pop
);

	prq_cmd_t    entry_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  fill_q;
	logic        push;
	prq_cmd_t    decoded;

	// classify the incoming word
	always_comb begin
		decoded.op   = req.cmd ? OP_READ : OP_WRITE;
		decoded.data = req.data_byte;
		decoded.last = req.last_byte;
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = entry_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= decoded;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (cmd_pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/prq_back.sv
// prq_back: executes queued commands against the slot memories, drives the result register
// depends on prq_pkg and prq_ram
module prq_back
	import prq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  prq_cmd_t cmd,
	output logic     cmd_pop,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output prq_rsp_t rsp
);

	prq_state_t        state_q, state_d;
	logic [SLOT_W-1:0] wslot_q, wslot_d;
	logic [SLOT_W-1:0] rslot_q, rslot_d;
	logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [OFS_W-1:0]  wofs_q, wofs_d;
	logic              drop_q, drop_d;
	logic [OFS_W-1:0]  idx_q, idx_d;
	logic [OFS_W-1:0]  rd_len_q, rd_len_d;
	logic [CNT_W-1:0]  rd_occ_q, rd_occ_d;
	logic              rsp_valid_q;
	prq_rsp_t          rsp_q, rsp_d;

	logic              out_free;
	logic              emit;
	logic              commit;
	logic              byte_we;
	logic [ADDR_W-1:0] byte_waddr;
	logic [ADDR_W-1:0] byte_raddr;
	logic [BYTE_W-1:0] byte_rdata;
	logic [LEN_W-1:0]  len_wdata;
	logic [LEN_W-1:0]  len_rdata;
	logic              start_full;
	logic              drop_now;
	logic              store;
	logic [OFS_W-1:0]  wofs_inc;
	logic              is_last;
	logic              advance;

	function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
		return ADDR_W'(s) * ADDR_W'(SLOT_BYTES);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	assign out_free = !rsp_valid_q || !rsp_stall;

	// write path helpers
	assign start_full = (wofs_q == '0) && !drop_q && (count_q == CNT_W'(SLOTS));
	assign drop_now   = drop_q || start_full;
	assign store      = (wofs_q < OFS_W'(SLOT_BYTES));
	assign wofs_inc   = store ? wofs_q + OFS_W'(1) : wofs_q;

	// read stream helpers
	assign is_last = ((idx_q + OFS_W'(1)) == rd_len_q);
	assign advance = (state_q == ST_RD_DATA) && out_free && !is_last;

	// memory ports
	assign byte_waddr = slot_base(wslot_q) + ADDR_W'(wofs_q);
	assign len_wdata  = LEN_W'(wofs_inc);
	assign byte_raddr = slot_base(cur_slot_q) + ADDR_W'(advance ? idx_q + OFS_W'(1) : idx_q);

	// sequencer: next state, results and memory writes
	always_comb begin
		state_d    = state_q;
		wslot_d    = wslot_q;
		rslot_d    = rslot_q;
		cur_slot_d = cur_slot_q;
		count_d    = count_q;
		wofs_d     = wofs_q;
		drop_d     = drop_q;
		idx_d      = idx_q;
		rd_len_d   = rd_len_q;
		rd_occ_d   = rd_occ_q;
		rsp_d      = '0;
		emit       = 1'b0;
		cmd_pop    = 1'b0;
		commit     = 1'b0;
		byte_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_WRITE) begin
						emit       = 1'b1;
						rsp_d.last = cmd.last;
						if (drop_now) begin
							drop_d          = !cmd.last;
							rsp_d.kind      = KIND_WR_FULL;
							rsp_d.occupancy = OCC_W'(count_q);
						end else begin
							byte_we             = store;
							rsp_d.kind          = KIND_WR_OK;
							rsp_d.packet_length = LEN_W'(wofs_inc);
							if (cmd.last) begin
								commit  = 1'b1;
								wslot_d = slot_next(wslot_q);
								count_d = count_q + CNT_W'(1);
								wofs_d  = '0;
							end else begin
								wofs_d = wofs_inc;
							end
							rsp_d.occupancy = OCC_W'(count_d);
						end
					end else if (count_q == '0) begin
						emit       = 1'b1;
						rsp_d.kind = KIND_RD_EMPTY;
						rsp_d.last = 1'b1;
					end else begin
						cur_slot_d = rslot_q;
						rslot_d    = slot_next(rslot_q);
						count_d    = count_q - CNT_W'(1);
						rd_occ_d   = count_q - CNT_W'(1);
						idx_d      = '0;
						state_d    = ST_RD_LEN;
					end
				end
			end
			ST_RD_LEN: begin
				// length ram output is valid now; clamp it to a sane run
				if (len_rdata > LEN_W'(SLOT_BYTES)) begin
					rd_len_d = OFS_W'(SLOT_BYTES);
				end else if (len_rdata == '0) begin
					rd_len_d = OFS_W'(1);
				end else begin
					rd_len_d = OFS_W'(len_rdata);
				end
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (out_free) begin
					emit                = 1'b1;
					rsp_d.kind          = KIND_RD_DATA;
					rsp_d.out_byte      = byte_rdata;
					rsp_d.packet_length = LEN_W'(rd_len_q);
					rsp_d.last          = is_last;
					rsp_d.occupancy     = OCC_W'(rd_occ_q);
					idx_d               = idx_q + OFS_W'(1);
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wslot_q     <= '0;
			rslot_q     <= '0;
			count_q     <= '0;
			wofs_q      <= '0;
			drop_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wslot_q <= wslot_d;
			rslot_q <= rslot_d;
			count_q <= count_d;
			wofs_q  <= wofs_d;
			drop_q  <= drop_d;
			if (out_free) begin
				rsp_valid_q <= emit;
			end
		end
	end

	// read run and result payload registers
	always_ff @(posedge clk) begin
		cur_slot_q <= cur_slot_d;
		idx_q      <= idx_d;
		rd_len_q   <= rd_len_d;
		rd_occ_q   <= rd_occ_d;
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// packet bytes, one slot of SLOT_BYTES per packet
	prq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SLOTS * SLOT_BYTES)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (cmd.data),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	// stored length per slot
	prq_ram #(
		.WIDTH (LEN_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (wslot_q),
		.wdata (len_wdata),
		.raddr (rslot_q),
		.rdata (len_rdata)
	);

	// packet count stays within the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("packet count above slot count");

	// a drop only runs from a packet boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (wofs_q == '0))
		else $error("drop in progress with partial packet");

	// read run index stays inside the packet
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_DATA) |-> (idx_q < rd_len_q) && (rd_len_q != '0))
		else $error("read index past packet length");

	// committing a packet raises the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("commit did not raise packet count");

endmodule

>>> sv/packet_ring_queue.sv
// packet_ring_queue: ring queue of whole packets in fixed slots (top level)
// write: one word per cycle unless a stall holds it; queued, then its result is registered
// read: the request is queued, the stored length is looked up, then the bytes are fetched, one per
// cycle unless rsp_stall holds it; the back end stays busy for the packet and the input stalls
// a two-word queue parts request acceptance from execution; results leave through a register
// reset clears pointers, count and handshake state; slot rams are not cleared
// depends on prq_pkg, prq_front, prq_back, prq_ram
module packet_ring_queue
	import prq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  prq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output prq_rsp_t rsp
);

	logic     cmd_valid;
	prq_cmd_t cmd;
	logic     cmd_pop;

	// accept and decode
	prq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// execute and stream results
	prq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
